### design/smfs_pkg.sv
// ----------------------------------------------------------------------------
// smfs_pkg
// Shared types and constants for the slice mode finder.
// ----------------------------------------------------------------------------
`default_nettype none

package smfs_pkg;

  localparam int VALUE_W = 64;
  localparam int TDATA_W = 64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch the accepted item
    logic search;     // match the value against the table, read its count
    logic update;     // count the element
    logic scan_init;  // seed the best candidate from the zero counters
    logic scan_step;  // read one table entry, compare the previous one
    logic emit;       // load the result register and clear the slice
  } smfs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic slice_full; // slice already holds its maximum number of elements
    logic item_last;  // latched item closes the slice
    logic scan_done;  // every table entry has been compared
    logic out_free;   // result register can take a new result
  } smfs_stat_t;

endpackage

`default_nettype wire

### design/smfs_ctrl.sv
// ----------------------------------------------------------------------------
// smfs_ctrl
// Sequencer: accepts one item at a time, steps counted elements through
// search and count update; a slice end runs the table scan and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module smfs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              in_tlast,
  input  wire logic              in_empty,
  output smfs_pkg::smfs_cmd_t    cmd,
  input  wire smfs_pkg::smfs_stat_t stat
);
  import smfs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_UPDATE = 5'b00100,
    S_SCAN   = 5'b01000,
    S_EMIT   = 5'b10000
  } smfs_state_t;

  smfs_state_t state_r, state_nxt;
  logic        accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_empty) begin
            state_nxt = S_EMIT;
          end else if (!stat.slice_full) begin
            state_nxt = S_SEARCH;
          end else if (in_tlast) begin
            // drop the element but still close the slice
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (stat.item_last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/smfs_dpath.sv
// ----------------------------------------------------------------------------
// smfs_dpath
// Datapath: value match lanes, count/position/value memories, zero counters,
// best-candidate scan and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module smfs_dpath #(
  parameter int MAX_DISTINCT = 64,
  parameter int MAX_SLICE    = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [smfs_pkg::TDATA_W-1:0]  in_tdata,  // [63:0] value_bits
  input  wire logic                          in_tlast,
  input  wire logic                          in_empty,
  input  wire smfs_pkg::smfs_cmd_t           cmd,
  output smfs_pkg::smfs_stat_t               stat,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [smfs_pkg::TDATA_W-1:0]       out_tdata, // [63:0] mode_bits
  output logic [0:0]                         out_tuser  // [0] table_overflow
);
  import smfs_pkg::*;

  localparam int IDX_W  = $clog2(MAX_DISTINCT);
  localparam int USED_W = $clog2(MAX_DISTINCT + 1);
  localparam int POS_W  = $clog2(MAX_SLICE);
  localparam int CNT_W  = $clog2(MAX_SLICE + 1);

  // latched item
  logic [VALUE_W-1:0] val_r;
  logic               last_r;
  logic               empty_r;

  // slice state
  logic [USED_W-1:0]  used_r;
  logic [CNT_W-1:0]   zero_cnt_r;
  logic [POS_W-1:0]   zero_first_r;
  logic               zero_hit_r;
  logic [CNT_W-1:0]   pos_r;
  logic               ovf_r;

  // match lanes and memories
  logic [VALUE_W-1:0] cam_r [MAX_DISTINCT];
  logic [CNT_W-1:0]   cnt_mem [MAX_DISTINCT];
  logic [POS_W-1:0]   pos_mem [MAX_DISTINCT];
  logic [VALUE_W-1:0] val_mem [MAX_DISTINCT];

  logic [MAX_DISTINCT-1:0] match;
  logic [IDX_W-1:0]   enc;
  logic               hit_r;
  logic [IDX_W-1:0]   idx_r;
  logic [CNT_W-1:0]   cnt_rd_r;
  logic [POS_W-1:0]   pos_rd_r;
  logic [VALUE_W-1:0] val_rd_r;

  // scan
  logic [USED_W-1:0]  scan_k_r;
  logic               pend_r;
  logic [CNT_W-1:0]   best_cnt_r;
  logic [POS_W-1:0]   best_pos_r;
  logic [VALUE_W-1:0] best_val_r;

  // result register
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_data_r;
  logic               out_ovf_r;

  logic               is_zero;
  logic               tab_full;
  logic               alloc;
  logic [IDX_W-1:0]   cnt_rd_addr;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_wr_addr;
  logic [CNT_W-1:0]   cnt_wr_data;
  logic               scan_more;
  logic               better;
  logic               zero_now;
  logic               seed_seen;
  logic [CNT_W-1:0]   seed_cnt;
  logic [POS_W-1:0]   seed_pos;

  assign is_zero   = (val_r[VALUE_W-2:0] == '0);
  assign tab_full  = (used_r == USED_W'(MAX_DISTINCT));
  assign alloc     = cmd.update && !is_zero && !hit_r && !tab_full;
  assign scan_more = (scan_k_r < used_r);
  assign better    = (cnt_rd_r > best_cnt_r) ||
                     ((cnt_rd_r == best_cnt_r) && (pos_rd_r < best_pos_r));

  // fold in a zero that is counted in the same cycle as the scan seed
  assign zero_now  = cmd.update && is_zero;
  assign seed_seen = zero_hit_r || zero_now;
  assign seed_cnt  = zero_now ? (zero_cnt_r + CNT_W'(1)) : zero_cnt_r;
  assign seed_pos  = zero_hit_r ? zero_first_r : pos_r[POS_W-1:0];

  // one comparator per lane; values are distinct so at most one lane hits
  always_comb begin
    match = '0;
    enc   = '0;
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      match[i] = (USED_W'(i) < used_r) && (cam_r[i] == val_r);
    end
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      if (match[i]) begin
        enc = enc | IDX_W'(i);
      end
    end
  end

  assign cnt_rd_addr = cmd.search ? enc : scan_k_r[IDX_W-1:0];
  assign cnt_we      = cmd.update && !is_zero && (hit_r || !tab_full);
  assign cnt_wr_addr = hit_r ? idx_r : used_r[IDX_W-1:0];
  assign cnt_wr_data = hit_r ? (cnt_rd_r + CNT_W'(1)) : CNT_W'(1);

  assign stat.slice_full = (pos_r >= CNT_W'(MAX_SLICE));
  assign stat.item_last  = last_r;
  assign stat.scan_done  = !scan_more && !pend_r;
  assign stat.out_free   = !out_valid_r || out_tready;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_ovf_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      zero_cnt_r  <= '0;
      zero_hit_r  <= 1'b0;
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      scan_k_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        pos_r <= pos_r + CNT_W'(1);
        if (is_zero) begin
          zero_cnt_r <= zero_cnt_r + CNT_W'(1);
          zero_hit_r <= 1'b1;
        end else if (!hit_r) begin
          if (tab_full) begin
            ovf_r <= 1'b1;
          end else begin
            used_r <= used_r + USED_W'(1);
          end
        end
      end
      if (cmd.scan_init) begin
        scan_k_r <= '0;
        pend_r   <= 1'b0;
      end else if (cmd.scan_step) begin
        pend_r <= scan_more;
        if (scan_more) begin
          scan_k_r <= scan_k_r + USED_W'(1);
        end
      end
      if (cmd.emit) begin
        used_r     <= '0;
        zero_cnt_r <= '0;
        zero_hit_r <= 1'b0;
        pos_r      <= '0;
        ovf_r      <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_r   <= in_tdata[VALUE_W-1:0];
      last_r  <= in_tlast;
      empty_r <= in_empty;
    end
    if (cmd.search) begin
      hit_r <= |match;
      idx_r <= enc;
    end
    if (cmd.update && is_zero && !zero_hit_r) begin
      zero_first_r <= pos_r[POS_W-1:0];
    end
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      if (alloc && (used_r == USED_W'(i))) begin
        cam_r[i] <= val_r;
      end
    end
    if (cmd.scan_init) begin
      best_cnt_r <= seed_seen ? seed_cnt : '0;
      best_pos_r <= seed_seen ? seed_pos : '1;
      best_val_r <= '0;
    end else if (cmd.scan_step && pend_r && better) begin
      best_cnt_r <= cnt_rd_r;
      best_pos_r <= pos_rd_r;
      best_val_r <= val_rd_r;
    end
    if (cmd.emit) begin
      out_data_r <= empty_r ? '0 : best_val_r;
      out_ovf_r  <= empty_r ? 1'b0 : ovf_r;
    end
  end

  // count memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    end
    if (cmd.search || cmd.scan_step) begin
      cnt_rd_r <= cnt_mem[cnt_rd_addr];
    end
  end

  // first position and value memories, written on allocation, read by the scan
  always_ff @(posedge clk) begin
    if (alloc) begin
      pos_mem[used_r[IDX_W-1:0]] <= pos_r[POS_W-1:0];
      val_mem[used_r[IDX_W-1:0]] <= val_r;
    end
    if (cmd.scan_step) begin
      pos_rd_r <= pos_mem[scan_k_r[IDX_W-1:0]];
      val_rd_r <= val_mem[scan_k_r[IDX_W-1:0]];
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(MAX_DISTINCT))
    else $error("table fill count beyond capacity");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("more than one table lane matches");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && (used_r == '0) && (pos_r == '0))
    else $error("result not presented or slice not cleared after emit");

  a_no_zero_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && is_zero |=> $stable(used_r))
    else $error("zero element allocated a table entry");

endmodule

`default_nettype wire

### design/slice_mode_first_seen.sv
// Sequencing: a counted element passes through accept, table match and count
// update; an element past the slice limit is dropped at acceptance. A closing
// element adds a scan of the used table entries through the count memory read
// port, then the result register load, which waits until that register is
// free. An empty-slice item goes from acceptance straight to the result load.
// Items are taken one at a time, a new one only when the last is through.
// Reset: synchronous active-low rst_n clears control state; no clearing pass.
// ----------------------------------------------------------------------------
// slice_mode_first_seen
// Mode of one slice of 64-bit patterns, ties going to the value seen first.
// ----------------------------------------------------------------------------
`default_nettype none

module slice_mode_first_seen #(
  parameter int MAX_DISTINCT = 64,
  parameter int MAX_SLICE    = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [smfs_pkg::TDATA_W-1:0]  in_tdata,   // [63:0] value_bits
  input  wire logic                          in_tlast,   // last_in_slice
  input  wire logic [0:0]                    in_tuser,   // [0] slice_empty
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [smfs_pkg::TDATA_W-1:0]       out_tdata,  // [63:0] mode_bits
  output logic [0:0]                         out_tuser   // [0] table_overflow
);
  import smfs_pkg::*;

  smfs_cmd_t  cmd;
  smfs_stat_t stat;

  smfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .in_empty  (in_tuser[0]),
    .cmd       (cmd),
    .stat      (stat)
  );

  smfs_dpath #(
    .MAX_DISTINCT (MAX_DISTINCT),
    .MAX_SLICE    (MAX_SLICE)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_empty   (in_tuser[0]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### dv/slice_mode_first_seen_test.sv
// ----------------------------------------------------------------------------
// slice_mode_first_seen_test
// Drives slices of 64-bit patterns into the mode finder and checks each
// result against a model of the table: counts, first positions, zero folding,
// table overflow, overlong slices and empty slices, with random stalls on
// both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module slice_mode_first_seen_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DISTINCT = 64;
  localparam int MAX_SLICE    = 1024;
  localparam int ITEM_TARGET  = 1950;

  typedef struct packed {
    logic [63:0] mode;
    logic        ovf;
  } mode_result_t;

  typedef enum int {SLICE_PLAIN, SLICE_WIDE, SLICE_NOISE, SLICE_BROKEN, SLICE_LONG} slice_kind_t;
  typedef enum int {READY_ALWAYS, READY_PATTERN, READY_SPARSE} ready_kind_t;

  // Tracks the slice being gathered and the modes it must produce.
  class mode_scoreboard;
    logic [63:0]  tbl_value [MAX_DISTINCT];
    int unsigned  tbl_count [MAX_DISTINCT];
    int unsigned  tbl_first [MAX_DISTINCT];
    int unsigned  n_entries;
    int unsigned  zero_hits;
    int unsigned  zero_first;
    int unsigned  slice_pos;
    bit           zero_present;
    bit           table_spilled;
    mode_result_t pending_modes[$];
    int           errors;
    int           results_seen;
    int           overflow_results;

    function new();
      errors = 0;
      results_seen = 0;
      overflow_results = 0;
      clear_slice();
    endfunction

    function void clear_slice();
      n_entries = 0;
      zero_hits = 0;
      zero_first = 0;
      zero_present = 1'b0;
      slice_pos = 0;
      table_spilled = 1'b0;
    endfunction

    function int pending_count();
      return pending_modes.size();
    endfunction

    function void note_item(logic [63:0] value, bit last, bit empty);
      mode_result_t r;
      int unsigned  top_count;
      int unsigned  best_pos;
      bit           matched;
      int           k;
      if (empty) begin
        clear_slice();
        r.mode = '0;
        r.ovf = 1'b0;
        pending_modes.insert(pending_modes.size(), r);
        return;
      end
      // Elements past the slice limit are dropped but may still close it.
      if (slice_pos < MAX_SLICE) begin
        matched = 1'b0;
        if (value[62:0] == '0) begin
          zero_hits++;
          if (!zero_present) begin
            zero_first = slice_pos;
            zero_present = 1'b1;
          end
          matched = 1'b1;
        end
        for (k = 0; k < n_entries && !matched; k++) begin
          if (tbl_value[k] == value) begin
            tbl_count[k]++;
            matched = 1'b1;
          end
        end
        if (!matched) begin
          if (n_entries < MAX_DISTINCT) begin
            tbl_value[n_entries] = value;
            tbl_count[n_entries] = 1;
            tbl_first[n_entries] = slice_pos;
            n_entries++;
          end else begin
            table_spilled = 1'b1;
          end
        end
        slice_pos++;
      end
      if (!last) return;
      // Seed with zero, then scan entries in allocation order.
      r.mode = '0;
      r.ovf = table_spilled;
      top_count = 0;
      best_pos = 32'hFFFF_FFFF;
      if (zero_present) begin
        top_count = zero_hits;
        best_pos = zero_first;
      end
      for (k = 0; k < n_entries; k++) begin
        if (tbl_count[k] > top_count ||
            (tbl_count[k] == top_count && tbl_first[k] < best_pos)) begin
          top_count = tbl_count[k];
          best_pos = tbl_first[k];
          r.mode = tbl_value[k];
        end
      end
      pending_modes.insert(pending_modes.size(), r);
      clear_slice();
    endfunction

    function void check_result(logic [63:0] mode, logic ovf);
      mode_result_t want;
      if (pending_modes.size() == 0) begin
        $display("%0t: unexpected result mode=%h overflow=%b", $time, mode, ovf);
        errors++;
        return;
      end
      want = pending_modes.pop_front();
      results_seen++;
      if (ovf) overflow_results++;
      if (mode !== want.mode) begin
        $display("%0t: mode_bits expected %h actual %h", $time, want.mode, mode);
        errors++;
      end
      if (ovf !== want.ovf) begin
        $display("%0t: table_overflow expected %b actual %b", $time, want.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [63:0] value_bits
  logic        in_tlast = 1'b0; // last_in_slice
  logic [0:0]  in_tuser = '0;   // [0] slice_empty
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [63:0] mode_bits
  logic [0:0]  out_tuser;       // [0] table_overflow

  mode_scoreboard sb = new();

  int          items_sent = 0;
  int          empty_items = 0;
  int          overlong_slices = 0;
  int          burst_left = 0;
  bit          steady_phase = 1'b1;
  logic [15:0] ready_pattern = 16'hFFFF;
  int          ready_cycle = 0;

  slice_mode_first_seen #(
    .MAX_DISTINCT(MAX_DISTINCT),
    .MAX_SLICE   (MAX_SLICE)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: rotate a stall pattern, and swap it periodically for a random one.
  always @(negedge clk) begin
    ready_kind_t kind;
    ready_cycle <= ready_cycle + 1;
    out_tready <= ready_pattern[ready_cycle % 16];
    if (ready_cycle % 256 == 255) begin
      kind = ready_kind_t'($urandom_range(READY_ALWAYS, READY_SPARSE));
      case (kind)
        READY_ALWAYS:  ready_pattern <= 16'hFFFF;
        READY_PATTERN: ready_pattern <= 16'($urandom) | 16'h0001;
        default:       ready_pattern <= 16'($urandom & $urandom & $urandom) | 16'h0001;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", sb.pending_count());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(input logic [63:0] value, input bit last, input bit empty);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    in_tuser  <= empty;
    do @(posedge clk); while (!in_tready);
    sb.note_item(value, last, empty);
    items_sent++;
    if (empty) empty_items++;
    if (!steady_phase) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic logic [63:0] pick_pattern();
    case ($urandom_range(0, 11))
      0:       return 64'h0000_0000_0000_0000;
      1:       return 64'h8000_0000_0000_0000;
      2:       return 64'hFFFF_FFFF_FFFF_FFFF;
      3:       return 64'h7FF8_0000_0000_0000;
      4:       return 64'hFFF8_0000_0000_0000;
      5:       return 64'h7FF0_0000_0000_0001;
      6:       return 64'h0000_0000_0000_0001;
      7:       return 64'h8000_0000_0000_0001;
      8:       return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Draw elements from a small pool, biased toward its first entries.
  task automatic play_slice(input int len, input int pool_n, input bit close);
    logic [63:0] pool [8];
    int          i;
    for (i = 0; i < pool_n; i++) pool[i] = pick_pattern();
    for (i = 0; i < len; i++)
      send_item(pool[$urandom_range(0, $urandom_range(0, pool_n - 1))],
                close && (i == len - 1), 1'b0);
  endtask

  // Mostly fresh values, to fill the table and spill past it.
  task automatic play_wide_slice(input int len);
    logic [63:0] seen[$];
    logic [63:0] value;
    int          i;
    for (i = 0; i < len; i++) begin
      if (seen.size() > 0 && $urandom_range(0, 99) < 20)
        value = seen[$urandom_range(0, seen.size() - 1)];
      else if ($urandom_range(0, 99) < 5)
        value = {1'($urandom_range(0, 1)), 63'd0};
      else
        value = {$urandom, $urandom};
      seen.insert(seen.size(), value);
      send_item(value, i == len - 1, 1'b0);
    end
  endtask

  initial begin
    slice_kind_t kind;
    bit          long_done;
    long_done = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Empty slices, with and without the last mark
    send_item({$urandom, $urandom}, 1'b0, 1'b1);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    // Single-element slices: all ones, negative zero
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_item(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    // Both zeros tie with a value; zero came first
    send_item(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    send_item(64'h0, 1'b0, 1'b0);
    send_item(64'h5, 1'b0, 1'b0);
    send_item(64'h5, 1'b1, 1'b0);
    // Tie where the nonzero value came first
    send_item(64'h5, 1'b0, 1'b0);
    send_item(64'h0, 1'b0, 1'b0);
    send_item(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    send_item(64'h5, 1'b1, 1'b0);
    // Zero closes the slice and tips the count
    send_item(64'h5, 1'b0, 1'b0);
    send_item(64'h0, 1'b0, 1'b0);
    send_item(64'h0, 1'b1, 1'b0);
    // Tie between two table entries
    send_item(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
    send_item(64'hFEDC_BA98_7654_3210, 1'b0, 1'b0);
    send_item(64'hFEDC_BA98_7654_3210, 1'b0, 1'b0);
    send_item(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
    // NaN patterns match by bits only
    send_item(64'h7FF8_0000_0000_0000, 1'b0, 1'b0);
    send_item(64'hFFF8_0000_0000_0000, 1'b0, 1'b0);
    send_item(64'h7FF8_0000_0000_0000, 1'b1, 1'b0);
    // Partial slice dropped by an empty item
    send_item(64'h7, 1'b0, 1'b0);
    send_item(64'h7, 1'b0, 1'b0);
    send_item(64'h7, 1'b0, 1'b1);
    send_item(64'h9, 1'b1, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 15) steady_phase = !steady_phase;
      if (!long_done && items_sent > 600) begin
        // Overlong slice: elements past the limit are ignored
        play_slice(MAX_SLICE + $urandom_range(1, 6), 3, 1'b1);
        overlong_slices++;
        long_done = 1'b1;
      end
      case ($urandom_range(0, 99))
        0, 1, 2, 3, 4, 5, 6, 7:    kind = SLICE_WIDE;
        8, 9, 10, 11, 12, 13, 14, 15, 16, 17: kind = SLICE_NOISE;
        18, 19, 20, 21, 22, 23, 24, 25: kind = SLICE_BROKEN;
        26, 27, 28:                kind = SLICE_LONG;
        default:                   kind = SLICE_PLAIN;
      endcase
      case (kind)
        SLICE_WIDE:   play_wide_slice($urandom_range(60, 84));
        SLICE_NOISE:  begin
          if ($urandom_range(0, 1))
            send_item({$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'b1);
          else
            send_item(pick_pattern(), 1'b1, 1'b0);
        end
        SLICE_BROKEN: begin
          play_slice($urandom_range(1, 10), $urandom_range(1, 4), 1'b0);
          send_item({$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'b1);
        end
        SLICE_LONG:   play_slice($urandom_range(30, 120), $urandom_range(2, 8), 1'b1);
        default:      play_slice($urandom_range(1, 24), $urandom_range(1, 6), 1'b1);
      endcase
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    // Hold for a full table scan in case of a stray result
    repeat (MAX_DISTINCT + 16) @(posedge clk);

    $display("Sent %0d items (%0d empty-slice, %0d overlong slice); checked %0d modes",
             items_sent, empty_items, overlong_slices, sb.results_seen);
    $display("%0d results reported table overflow", sb.overflow_results);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/smfs_pkg.sv
design/smfs_ctrl.sv
design/smfs_dpath.sv
design/slice_mode_first_seen.sv
dv/slice_mode_first_seen_test.sv
